// ===== src/lzfbd_pkg.sv =====
// Package for the LZSS flag-byte decompressor: codes, state encoding and
// the result record shared by the top level. No dependencies.
package lzfbd_pkg;

  // History ring geometry (fixed by the 12-bit offset of the format)
  localparam int HistDepth = 4096;
  localparam int HistAddrW = 12;

  // Input operation codes (carried on tuser)
  localparam logic OpByte  = 1'b0;
  localparam logic OpAbort = 1'b1;

  // Result kinds (carried on tuser)
  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // End-of-block status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StMismatch = 2'd1;
  localparam logic [1:0] StAborted  = 2'd2;

  // Configuration register indexes
  localparam int            RegIdxW       = 1;
  localparam logic [RegIdxW-1:0] RegInputSize  = 1'b0;
  localparam logic [RegIdxW-1:0] RegOutputSize = 1'b1;

  localparam int CfgDataW = 24;

  // Sequencer states
  typedef enum logic [3:0] {
    SIdle  = 4'b0001,
    SRead  = 4'b0010,
    SWrite = 4'b0100,
    SPush  = 4'b1000
  } state_e;

  // One result item
  typedef struct packed {
    logic               kind;
    logic [7:0]         out_byte;
    logic [1:0]         status;
    logic signed [24:0] leftover;
    logic [23:0]        count;
    logic               last;
  } res_t;

endpackage

// ===== src/lzfbd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module lzfbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lzss_flag_byte_decompressor.sv =====
// Top level of the LZSS flag-byte decompressor (12-bit offset, 4-bit length).
// Uses lzfbd_pkg and one lzfbd_ram instance for the 4096-byte history ring.
//
// Usage:
//   Input stream (s_axis): one compressed byte per transaction on tdata,
//   tuser = 1 requests an abort of the current block (tdata ignored).
//   Output stream (m_axis): decompressed bytes (tuser = 0) and one status
//   record per block end (tuser = 1); tlast marks the final result caused
//   by one input transaction.
//   Config channel: cfg_index_i selects input_block_size (0) or
//   expected_output_size (1); always ready. Write only while idle.
// Sequencing:
//   Flag bytes, literals and the first byte of a match are taken in the idle
//   state; the input is ready again in the next cycle unless a result must
//   wait in the pending record. The second byte of a match starts a copy of
//   length field + 2 bytes; each byte is read from the ring (registered
//   read) and then written back and sent out, stalling while the output is
//   busy.
// Reset: clears all control state and the counters. The ring needs no
//   clearing pass: entries never written since reset read as zero through
//   fill tracking of the write pointer.
// Stalls: one output register plus one pending record; a result that finds the
//   output busy waits in the pending record or the copy holds; input not ready.
module lzss_flag_byte_decompressor
  import lzfbd_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // compressed input
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // [7:0] in_byte
  input  logic                s_axis_tuser_i,   // [0] op
  // decompressed output
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [7:0] out_byte, [9:8] status, [34:10] leftover_input,
  // [58:35] output_count, [63:59] zero
  output logic [63:0]         m_axis_tdata_o,
  output logic                m_axis_tuser_o,   // [0] kind
  output logic                m_axis_tlast_o,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [RegIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int ExtW = (COUNT_BITS > 25) ? COUNT_BITS : 25;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  state_e                 state_q, state_d;
  logic [7:0]             flags_q, flags_d;
  logic [3:0]             left_q, left_d;
  logic                   phase_q, phase_d;
  logic [7:0]             mfb_q, mfb_d;
  logic [HistAddrW-1:0]   wp_q, wp_d;
  logic                   full_q, full_d;
  logic [COUNT_BITS-1:0]  cons_q, cons_d;
  logic [COUNT_BITS-1:0]  prod_q, prod_d;
  logic [HistAddrW-1:0]   src_q, src_d;
  logic [4:0]             rem_q, rem_d;
  logic                   hit_q, hit_d;
  logic [CfgDataW-1:0]    ibs_q, eos_q;
  res_t                   out_q, out_d;
  res_t                   pend_q, pend_d;
  logic                   out_valid_q, out_valid_d;

  logic                   in_acc;
  logic                   out_free;
  logic                   out_load;
  res_t                   res;
  logic                   ram_we;
  logic                   ram_re;
  logic [7:0]             ram_wdata;
  logic [7:0]             ram_rdata;

  logic [COUNT_BITS-1:0]  cons_inc;
  logic [COUNT_BITS-1:0]  prod_inc;
  logic [COUNT_BITS-1:0]  cons_use;
  logic [ExtW-1:0]        cons_ext;
  logic [ExtW-1:0]        prod_ext;
  logic [ExtW-1:0]        ibs_ext;
  logic [ExtW-1:0]        eos_ext;
  logic [ExtW-1:0]        diff_ext;
  logic [HistAddrW-1:0]   offset;
  logic                   end_ok;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // saturating counters and end-of-block figures
  assign cons_inc = (cons_q == CountMax) ? cons_q : cons_q + COUNT_BITS'(1);
  assign prod_inc = (prod_q == CountMax) ? prod_q : prod_q + COUNT_BITS'(1);
  assign cons_use = (s_axis_tuser_i == OpAbort) ? cons_q : cons_inc;
  assign cons_ext = ExtW'(cons_use);
  assign prod_ext = ExtW'(prod_q);
  assign ibs_ext  = ExtW'(ibs_q);
  assign eos_ext  = ExtW'(eos_q);
  assign diff_ext = ibs_ext - cons_ext;
  assign end_ok   = (ibs_ext == cons_ext) && (prod_ext == eos_ext);
  assign offset   = {mfb_q[7:4], s_axis_tdata_i};

  // sequencer
  always_comb begin
    state_d   = state_q;
    flags_d   = flags_q;
    left_d    = left_q;
    phase_d   = phase_q;
    mfb_d     = mfb_q;
    wp_d      = wp_q;
    full_d    = full_q;
    cons_d    = cons_q;
    prod_d    = prod_q;
    src_d     = src_q;
    rem_d     = rem_q;
    hit_d     = hit_q;
    pend_d    = pend_q;
    out_load  = 1'b0;
    res       = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = s_axis_tdata_i;

    unique case (state_q)
      SIdle: begin
        if (in_acc) begin
          if (s_axis_tuser_i == OpAbort || (phase_q && offset == '0 && mfb_q[3:0] == 4'd0))
          begin
            // end of block: abort or end marker
            res.kind     = KindStatus;
            res.status   = (s_axis_tuser_i == OpAbort) ? StAborted :
                           (end_ok ? StOk : StMismatch);
            res.leftover = diff_ext[24:0];
            res.count    = prod_ext[23:0];
            res.last     = 1'b1;
            flags_d = '0;
            left_d  = '0;
            phase_d = 1'b0;
            mfb_d   = '0;
            cons_d  = '0;
            prod_d  = '0;
            if (out_free) begin
              out_load = 1'b1;
            end else begin
              pend_d  = res;
              state_d = SPush;
            end
          end else begin
            cons_d = cons_inc;
            if (phase_q) begin
              // second match byte: start the copy
              flags_d = {1'b0, flags_q[7:1]};
              left_d  = left_q - 4'd1;
              phase_d = 1'b0;
              src_d   = wp_q - offset;
              rem_d   = {1'b0, mfb_q[3:0]} + 5'd1;
              state_d = SRead;
            end else if (left_q == 4'd0) begin
              flags_d = s_axis_tdata_i;
              left_d  = 4'd8;
            end else if (flags_q[0]) begin
              // literal
              res.kind     = KindData;
              res.out_byte = s_axis_tdata_i;
              res.last     = 1'b1;
              ram_we  = 1'b1;
              wp_d    = wp_q + HistAddrW'(1);
              full_d  = full_q || (&wp_q);
              prod_d  = prod_inc;
              flags_d = {1'b0, flags_q[7:1]};
              left_d  = left_q - 4'd1;
              if (out_free) begin
                out_load = 1'b1;
              end else begin
                pend_d  = res;
                state_d = SPush;
              end
            end else begin
              mfb_d   = s_axis_tdata_i;
              phase_d = 1'b1;
            end
          end
        end
      end
      SRead: begin
        // read one history byte; unwritten entries count as zero
        ram_re  = 1'b1;
        hit_d   = full_q || (src_q < wp_q);
        state_d = SWrite;
      end
      SWrite: begin
        if (out_free) begin
          res.kind     = KindData;
          res.out_byte = hit_q ? ram_rdata : 8'd0;
          res.last     = (rem_q == 5'd0);
          out_load  = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = res.out_byte;
          wp_d      = wp_q + HistAddrW'(1);
          full_d    = full_q || (&wp_q);
          prod_d    = prod_inc;
          src_d     = src_q + HistAddrW'(1);
          rem_d     = rem_q - 5'd1;
          state_d   = (rem_q == 5'd0) ? SIdle : SRead;
        end
      end
      SPush: begin
        if (out_free) begin
          res      = pend_q;
          out_load = 1'b1;
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      flags_q     <= '0;
      left_q      <= '0;
      phase_q     <= 1'b0;
      mfb_q       <= '0;
      wp_q        <= '0;
      full_q      <= 1'b0;
      cons_q      <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      ibs_q       <= '0;
      eos_q       <= '0;
    end else begin
      state_q     <= state_d;
      flags_q     <= flags_d;
      left_q      <= left_d;
      phase_q     <= phase_d;
      mfb_q       <= mfb_d;
      wp_q        <= wp_d;
      full_q      <= full_d;
      cons_q      <= cons_d;
      prod_q      <= prod_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegInputSize) begin
          ibs_q <= cfg_data_i;
        end
        if (cfg_index_i == RegOutputSize) begin
          eos_q <= cfg_data_i;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
    src_q  <= src_d;
    rem_q  <= rem_d;
    hit_q  <= hit_d;
  end

  // history ring
  lzfbd_ram #(
    .WIDTH(8),
    .DEPTH(HistDepth)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(src_q),
    .rdata_o(ram_rdata)
  );

  // ports
  assign s_axis_tready_o = (state_q == SIdle);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {5'd0, out_q.count, out_q.leftover, out_q.status, out_q.out_byte};

  // checks
  a_push_has_blocked_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SPush |-> out_valid_q)
    else $error("pending result while output register is free");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KindStatus) |-> out_q.last)
    else $error("status result without last");

  a_ring_write_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> wp_q == $past(wp_q) + HistAddrW'(1))
    else $error("write pointer did not advance after ring write");

  a_copy_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SWrite && out_free && rem_q == 5'd0) |=> (out_q.last && state_q == SIdle))
    else $error("match copy ended without last result");

  a_read_then_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SRead |=> state_q == SWrite)
    else $error("ring read not followed by write step");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for lzss_flag_byte_decompressor: streams compressed
// bytes and aborts, predicts every decoded byte and end-of-block record.
// Depends on lzfbd_pkg and the decompressor RTL only.
module tb_top;
  import lzfbd_pkg::*;

  typedef enum int {SinkOpen, SinkRandom, SinkPeriodic} sink_mode_e;

  localparam int IdlePad = 16;  // cycles the block may still be busy with no result

  // Clock, reset and block-facing signals
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_op = OpByte;
  logic [7:0]          s_byte = 8'h00;
  logic                s_ready;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [63:0]         m_data;
  logic                m_kind;
  logic                m_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [RegIdxW-1:0]  cfg_index = RegInputSize;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Decoder model state
  logic [7:0]           tok_flags;
  logic [3:0]           tok_left;
  logic                 want_second;
  logic [7:0]           match_hdr;
  logic [HistAddrW-1:0] hist_wr;
  logic [23:0]          n_consumed;
  logic [23:0]          n_produced;
  logic [7:0]           hist [HistDepth];
  logic [23:0]          cfg_in_size;
  logic [23:0]          cfg_out_size;

  // Expected decoded results, oldest first
  res_t decoded_q[$];

  // Bookkeeping
  int errors = 0;
  int n_checked = 0;
  int items_sent = 0;
  int n_ok = 0;
  int n_mismatch = 0;
  int n_aborted = 0;
  int burst_left = 1;
  bit gaps_on = 1'b1;
  int hold_len = 0;

  lzss_flag_byte_decompressor dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_byte),
    .s_axis_tuser_i  (s_op),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_kind),
    .m_axis_tlast_o  (m_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------

  // One decoded byte: goes to the history and to the expected results
  function automatic void emit_data(logic [7:0] c, logic fin);
    res_t r;
    hist[hist_wr] = c;
    hist_wr++;
    if (n_produced != '1) n_produced++;
    r = '0;
    r.kind = KindData;
    r.out_byte = c;
    r.last = fin;
    decoded_q.push_back(r);
  endfunction

  // End-of-block record; clears the per-block state, keeps the history
  function automatic void emit_status(logic aborted);
    res_t r;
    logic [24:0] left;
    left = {1'b0, cfg_in_size} - {1'b0, n_consumed};
    r = '0;
    r.kind = KindStatus;
    r.leftover = left;
    r.count = n_produced;
    r.last = 1'b1;
    if (aborted) begin
      r.status = StAborted;
      n_aborted++;
    end else if (left == '0 && n_produced == cfg_out_size) begin
      r.status = StOk;
      n_ok++;
    end else begin
      r.status = StMismatch;
      n_mismatch++;
    end
    decoded_q.push_back(r);
    tok_flags = '0;
    tok_left = '0;
    want_second = 1'b0;
    match_hdr = '0;
    n_consumed = '0;
    n_produced = '0;
  endfunction

  // Work out the results of one accepted input transaction
  function automatic void decode_item(logic op, logic [7:0] b);
    logic [HistAddrW-1:0] src;
    logic [HistAddrW-1:0] offset;
    int len;
    int i;
    if (op == OpAbort) begin
      emit_status(1'b1);
    end else begin
      if (n_consumed != '1) n_consumed++;
      if (want_second) begin
        offset = {match_hdr[7:4], b};
        len = int'(match_hdr[3:0]) + 2;
        tok_flags = tok_flags >> 1;
        tok_left--;
        want_second = 1'b0;
        if (offset == '0 && match_hdr[3:0] == 4'd0) begin
          emit_status(1'b0);
        end else begin
          // byte-wise copy so overlapping matches repeat their pattern
          src = hist_wr - offset;
          for (i = 0; i < len; i++) begin
            emit_data(hist[src], i == len - 1);
            src++;
          end
        end
      end else if (tok_left == '0) begin
        tok_flags = b;
        tok_left = 4'd8;
      end else if (tok_flags[0]) begin
        emit_data(b, 1'b1);
        tok_flags = tok_flags >> 1;
        tok_left--;
      end else begin
        match_hdr = b;
        want_second = 1'b1;
      end
    end
  endfunction

  function automatic void clear_model();
    tok_flags = '0;
    tok_left = '0;
    want_second = 1'b0;
    match_hdr = '0;
    hist_wr = '0;
    n_consumed = '0;
    n_produced = '0;
    cfg_in_size = '0;
    cfg_out_size = '0;
    foreach (hist[i]) hist[i] = '0;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  task automatic report_error(input string msg);
    errors++;
    if (errors <= 30) $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0h, expected %0h",
                             n_checked, name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && m_valid && m_ready) begin
      if (decoded_q.size() == 0) begin
        report_error($sformatf("result with nothing pending: kind %0b tdata %h",
                               m_kind, m_data));
      end else begin
        want = decoded_q.pop_front();
        n_checked++;
        check_field("kind", 32'(m_kind), 32'(want.kind));
        check_field("out_byte", 32'(m_data[7:0]), 32'(want.out_byte));
        check_field("status", 32'(m_data[9:8]), 32'(want.status));
        check_field("leftover", {7'd0, m_data[34:10]}, {7'd0, want.leftover});
        check_field("output_count", 32'(m_data[58:35]), 32'(want.count));
        check_field("last", 32'(m_last), 32'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: changing stall patterns, plus long hold-offs on request
  // ---------------------------------------------------------------------
  initial begin : sink_pattern
    sink_mode_e mode;
    int mode_left;
    int period;
    int on_len;
    int tick;
    mode = SinkOpen;
    mode_left = 0;
    period = 2;
    on_len = 1;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        m_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 200);
          period = $urandom_range(2, 6);
          on_len = $urandom_range(1, period - 1);
        end
        mode_left--;
        tick++;
        case (mode)
          SinkOpen:   m_ready <= 1'b1;
          SinkRandom: m_ready <= ($urandom_range(0, 9) < 7);
          default:    m_ready <= ((tick % period) < on_len);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offer one item until accepted; bursts with random gaps between them when gaps_on is set
  task automatic send_item(input logic op, input logic [7:0] b);
    s_valid <= 1'b1;
    s_op <= op;
    s_byte <= b;
    do @(posedge clk); while (!s_ready);
    decode_item(op, b);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait for every expected result
  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk); while (decoded_q.size() != 0);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == RegInputSize) cfg_in_size = val;
    else cfg_out_size = val;
  endtask

  // Registers change only once the block has gone quiet
  task automatic config_sizes(input logic [23:0] in_size, input logic [23:0] out_size);
    wait_drained();
    repeat (IdlePad) @(posedge clk);
    write_reg(RegInputSize, in_size);
    write_reg(RegOutputSize, out_size);
    cfg_valid <= 1'b0;
  endtask

  // Well-formed block with random tokens, closed by the end marker.
  // Optionally sizes are written to match it (sometimes off by one), or it is cut short by an abort.
  task automatic send_block(input bit set_sizes, input bit do_abort);
    logic [7:0] blk[$];
    logic [7:0] flags;
    logic [11:0] offset;
    logic [3:0] lenf;
    int n_tok;
    int tok;
    int out_len;
    int cut;
    int pause_at;
    int in_len;
    int i;
    n_tok = $urandom_range(0, 14);
    out_len = 0;
    flags = '0;
    for (tok = 0; tok <= n_tok; tok++) begin
      if (tok % 8 == 0) begin
        flags = 8'($urandom);
        if (tok / 8 == n_tok / 8) flags[n_tok % 8] = 1'b0;
        blk.push_back(flags);
      end
      if (tok == n_tok) begin
        // end marker: offset zero, length field zero
        blk.push_back(8'h00);
        blk.push_back(8'h00);
      end else if (flags[tok % 8]) begin
        blk.push_back(8'($urandom));
        out_len++;
      end else begin
        lenf = 4'($urandom);
        case ($urandom_range(0, 9))
          0:       offset = '0;
          1, 2:    offset = 12'($urandom_range(1, 4095));
          default: offset = 12'($urandom_range(1, 24));
        endcase
        if (offset == '0 && lenf == 4'd0) lenf = 4'd1;
        blk.push_back({offset[11:8], lenf});
        blk.push_back(offset[7:0]);
        out_len += int'(lenf) + 2;
      end
    end
    if (set_sizes) begin
      in_len = blk.size();
      if ($urandom_range(0, 3) == 0) begin
        in_len += int'($urandom_range(0, 2)) - 1;
        out_len += int'($urandom_range(0, 2)) - 1;
      end
      config_sizes(24'(in_len), 24'(out_len));
    end
    cut = do_abort ? $urandom_range(0, blk.size() - 1) : blk.size();
    pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, blk.size() - 1) : -1;
    for (i = 0; i < cut; i++) begin
      if (i == pause_at) wait_drained();
      send_item(OpByte, blk[i]);
    end
    if (do_abort) send_item(OpAbort, 8'($urandom));
  endtask

  // Random items of either kind, then an abort to bring framing back
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_item(($urandom_range(0, 9) == 0) ? OpAbort : OpByte, 8'($urandom));
    send_item(OpAbort, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Literal extremes, longest match into unwritten history, an overlapping
  // match, offset zero with a length, and the end marker; run with reset
  // sizes (mismatch), then with matching sizes (ok); then an abort mid-block.
  task automatic test_directed_tokens();
    logic [7:0] blk [11];
    int pass;
    blk = '{8'h03, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h01, 8'h00,
            8'h00, 8'h00};
    for (pass = 0; pass < 2; pass++) begin
      if (pass == 1) config_sizes(24'd11, 24'd24);
      foreach (blk[i]) send_item(OpByte, blk[i]);
    end
    send_item(OpByte, 8'hFF);
    send_item(OpByte, 8'h5A);
    send_item(OpAbort, 8'hA5);
    send_item(OpAbort, 8'h00);
  endtask

  // Size registers at their extremes around empty blocks
  task automatic test_size_registers();
    config_sizes(24'hFFFFFF, 24'hFFFFFF);
    send_item(OpByte, {7'($urandom), 1'b0});
    send_item(OpByte, 8'h00);
    send_item(OpByte, 8'h00);
    config_sizes(24'd3, 24'd0);
    send_item(OpByte, 8'hFE);
    send_item(OpByte, 8'h00);
    send_item(OpByte, 8'h00);
    config_sizes(24'd0, 24'hFFFFFF);
    send_item(OpAbort, 8'hFF);
    config_sizes(24'($urandom), 24'($urandom));
    send_block(1'b0, 1'b0);
  endtask

  // Receiver holds off for a long stretch while long matches keep coming
  task automatic test_backpressure();
    int i;
    config_sizes(24'd11, 24'd68);
    hold_len = 300;
    send_item(OpByte, 8'h00);
    for (i = 0; i < 4; i++) begin
      send_item(OpByte, 8'h0F);
      send_item(OpByte, 8'h01);
    end
    send_item(OpByte, 8'h00);
    send_item(OpByte, 8'h00);
    hold_len = 200;
    send_item(OpByte, 8'hFF);
    for (i = 0; i < 8; i++) send_item(OpByte, 8'($urandom));
    send_item(OpAbort, 8'($urandom));
    wait_drained();
  endtask

  // Mostly well-formed blocks, some cut short by aborts, some noise
  task automatic test_random_stream();
    int target;
    int pick;
    target = items_sent + 250;
    while (items_sent < target) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) send_block($urandom_range(0, 3) != 0, 1'b0);
      else if (pick < 85) send_block($urandom_range(0, 1), 1'b1);
      else send_noise();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    clear_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_tokens();
    test_size_registers();
    test_backpressure();
    test_random_stream();

    wait_drained();
    repeat (40) @(posedge clk);
    $display("Summary: %0d input items accepted, %0d results checked",
             items_sent, n_checked);
    $display("Summary: blocks ended ok %0d, size mismatch %0d, aborted %0d",
             n_ok, n_mismatch, n_aborted);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lzfbd_pkg.sv
src/lzfbd_ram.sv
src/lzss_flag_byte_decompressor.sv
tb/tb_top.sv
